// ===== rtl/core/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude core.
package sem_pkg;

  localparam int PixW = 24;
  localparam int ChanW = 8;
  localparam int RowW = 17;
  localparam int CfgDataW = 16;
  localparam int GradW = 12;
  localparam int SumW = 22;
  localparam int RemW = 17;
  localparam int RootSteps = 8;
  localparam int StepW = 3;
  localparam logic [SumW-1:0] SatLimit = SumW'(65280);
  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  localparam logic CfgIdxWidth = 1'b0;
  localparam logic CfgIdxHeight = 1'b1;

  localparam logic ModePixel = 1'b0;
  localparam logic ModeFlush = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [ChanW-1:0] pixel_red;
    logic [ChanW-1:0] pixel_green;
    logic [ChanW-1:0] pixel_blue;
  } sem_in_t;

  typedef struct packed {
    logic [ChanW-1:0] edge_red;
    logic [ChanW-1:0] edge_green;
    logic [ChanW-1:0] edge_blue;
    logic             frame_end;
  } sem_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_GRAD,
    ST_SQR,
    ST_ROOT,
    ST_OUT
  } sem_state_e;

  typedef struct packed {
    logic             load;
    logic             line;
    logic             grad;
    logic             sqr;
    logic             root;
    logic [StepW-1:0] bit_idx;
    logic             out_load;
  } sem_cmd_t;

  typedef struct packed {
    logic drop;
    logic emit;
    logic out_free;
  } sem_sts_t;

endpackage

// ===== rtl/core/sobel_edge_magnitude_rgb_core.sv =====
// Top level of the RGB Sobel edge magnitude core.
//
//  channel | signals                          | moves
//  --------+----------------------------------+-------------------------------
//  in      | in_valid_i/in_ready_o/in_data_i  | one pixel or flush word
//  out     | out_valid_o/out_ready_i/out_data_o | one magnitude word, lags a row+1
//  cfg     | cfg_we_i/cfg_idx_i/cfg_data_i    | width (0) or height (1) write
//
// A word that yields a result holds off the next accept until the output loads; the
// output loads after one line store read, gradients, squares and eight root steps
// (each lane runs its own root iteration). A word with no result returns to idle
// after the line store step; a dropped flush is taken while the sequencer stays idle.
// Line stores need no clearing after reset. A stalled output holds the sequencer
// in its last step; the output register frees the input side once loaded.
module sobel_edge_magnitude_rgb_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sem_pkg::sem_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sem_pkg::sem_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [sem_pkg::CfgDataW-1:0]  cfg_data_i
);

  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sem_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/sem_ram.sv =====
// Generic single-port RAM with registered read.
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sem_ctrl.sv =====
// Sequencer for one word: line store access, gradients, squares, root steps, output.
module sem_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sem_pkg::sem_sts_t   sts_i,
  output sem_pkg::sem_cmd_t   cmd_o
);

  sem_pkg::sem_state_e          state_q, state_d;
  logic [sem_pkg::StepW-1:0]    step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sem_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      sem_pkg::ST_IDLE: begin
        if (in_valid_i && !sts_i.drop) state_d = sem_pkg::ST_LINE;
      end
      sem_pkg::ST_LINE: begin
        state_d = sts_i.emit ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
      end
      sem_pkg::ST_GRAD: state_d = sem_pkg::ST_SQR;
      sem_pkg::ST_SQR: begin
        state_d = sem_pkg::ST_ROOT;
        step_d  = sem_pkg::StepW'(sem_pkg::RootSteps - 1);
      end
      sem_pkg::ST_ROOT: begin
        step_d = step_q - 1'b1;
        if (step_q == '0) state_d = sem_pkg::ST_OUT;
      end
      sem_pkg::ST_OUT: begin
        if (sts_i.out_free) state_d = sem_pkg::ST_IDLE;
      end
      default: state_d = sem_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.bit_idx = step_q;
    in_ready_o    = 1'b0;
    unique case (state_q)
      sem_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      sem_pkg::ST_LINE: cmd_o.line = 1'b1;
      sem_pkg::ST_GRAD: cmd_o.grad = 1'b1;
      sem_pkg::ST_SQR:  cmd_o.sqr  = 1'b1;
      sem_pkg::ST_ROOT: cmd_o.root = 1'b1;
      sem_pkg::ST_OUT:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/sem_dp.sv =====
// Datapath: config, positions, line stores, window, gradient and root lanes, output register.
module sem_dp #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sem_pkg::sem_in_t              in_data_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [sem_pkg::CfgDataW-1:0]  cfg_data_i,
  input  sem_pkg::sem_cmd_t             cmd_i,
  output sem_pkg::sem_sts_t             sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sem_pkg::sem_out_t             out_data_o
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > 11) ? CW : 11;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int TW = WW + 16;
  localparam int PW = sem_pkg::PixW;
  localparam int RW = sem_pkg::RowW;
  localparam int GW = sem_pkg::GradW;

  // configuration
  logic [10:0] width_q;
  logic [15:0] height_q;
  logic [WW-1:0] w_eff, w_raw;
  logic [15:0]   h_eff;
  logic [TW-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 16'd480;
      total_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == sem_pkg::CfgIdxWidth) width_q <= cfg_data_i[10:0];
      if (cfg_we_i && cfg_idx_i == sem_pkg::CfgIdxHeight) height_q <= cfg_data_i;
      total_q <= TW'(w_eff) * TW'(h_eff);
    end
  end

  assign w_raw = WW'(width_q);
  assign w_eff = (width_q == '0) ? WW'(1) :
                 ((w_raw > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_raw);
  assign h_eff = (height_q == '0) ? 16'd1 : height_q;

  // positions
  logic [WW-1:0] col_q, col_cur_q, col_wrap, col_inc;
  logic [RW-1:0] row_q;
  logic [TW-1:0] cnt_q;
  logic          in_frame;
  logic [PW-1:0] pix_q;

  assign col_wrap = (col_q >= w_eff) ? '0 : col_q;
  assign in_frame = row_q < RW'(h_eff);
  assign col_inc  = col_cur_q + 1'b1;

  // line stores
  logic [AW-1:0] ram_addr;
  logic [PW-1:0] up_rd, mid_rd;

  assign ram_addr = cmd_i.load ? col_wrap[AW-1:0] : col_cur_q[AW-1:0];

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line),
    .addr_i  (ram_addr),
    .wdata_i (mid_rd),
    .rdata_o (up_rd)
  );

  sem_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.line),
    .addr_i  (ram_addr),
    .wdata_i (pix_q),
    .rdata_o (mid_rd)
  );

  // emit decision and border masks for the center pixel
  logic          emit, last;
  logic [RW-1:0] crow;
  logic [WW-1:0] ccol;
  logic          left_col;
  logic [2:0]    row_ok_d, col_ok_d;
  logic [2:0]    row_ok_q, col_ok_q;
  logic [TW-1:0] cnt_inc;

  assign left_col = (col_cur_q == '0);
  assign emit = ((row_q >= RW'(2)) || (row_q == RW'(1) && !left_col)) && (cnt_q < total_q);
  assign crow = left_col ? row_q - RW'(2) : row_q - RW'(1);
  assign ccol = left_col ? w_eff - 1'b1 : col_cur_q - 1'b1;
  assign row_ok_d = {(crow + 1'b1) < RW'(h_eff), 1'b1, crow != '0};
  assign col_ok_d = {(ccol + 1'b1) < w_eff, 1'b1, ccol != '0};
  assign cnt_inc  = cnt_q + 1'b1;
  assign last     = cnt_inc >= total_q;

  logic frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.line) begin
      if (emit && last) begin
        col_q <= '0;
        row_q <= '0;
        cnt_q <= '0;
      end else begin
        if (emit) cnt_q <= cnt_inc;
        if (col_inc >= w_eff) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_inc;
        end
      end
    end
  end

  // window [row][col], col 2 newest
  logic [PW-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (cmd_i.line) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_rd;
      win_q[1][2] <= mid_rd;
      win_q[2][2] <= pix_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_cur_q <= col_wrap;
      pix_q     <= in_frame ? {in_data_i.pixel_red, in_data_i.pixel_green,
                               in_data_i.pixel_blue} : '0;
    end
    if (cmd_i.line) begin
      row_ok_q    <= row_ok_d;
      col_ok_q    <= col_ok_d;
      frame_end_q <= last;
    end
  end

  // per-channel lanes: gradients, squares, root
  logic signed [GW-1:0]             tap [3][3][3];
  logic signed [GW-1:0]             gx_d [3], gy_d [3];
  logic signed [GW-1:0]             gx_q [3], gy_q [3];
  logic [sem_pkg::SumW-1:0]         sum_d [3];
  logic [sem_pkg::RemW-1:0]         rem_q [3];
  logic [sem_pkg::ChanW-1:0]        root_q [3];
  logic                             sat_q [3];
  logic [sem_pkg::ChanW-1:0]        bitv;
  logic [sem_pkg::RemW-1:0]         trial [3];
  logic [sem_pkg::ChanW-1:0]        res [3];

  assign bitv = sem_pkg::ChanW'(1) << cmd_i.bit_idx;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          tap[ch][r][c] = (row_ok_q[r] && col_ok_q[c]) ?
              GW'(win_q[r][c][(2 - ch) * 8 +: 8]) : '0;
        end
      end
      gx_d[ch] = GW'((tap[ch][0][2] + 2 * tap[ch][1][2] + tap[ch][2][2])
               - (tap[ch][0][0] + 2 * tap[ch][1][0] + tap[ch][2][0]));
      gy_d[ch] = GW'((tap[ch][2][0] + 2 * tap[ch][2][1] + tap[ch][2][2])
               - (tap[ch][0][0] + 2 * tap[ch][0][1] + tap[ch][0][2]));
      // operands sign-extended first so the squares keep all their bits
      sum_d[ch] = sem_pkg::SumW'(gx_q[ch]) * sem_pkg::SumW'(gx_q[ch])
                + sem_pkg::SumW'(gy_q[ch]) * sem_pkg::SumW'(gy_q[ch]);
      trial[ch] = ({8'b0, root_q[ch], 1'b0} + {9'b0, bitv}) << cmd_i.bit_idx;
      if (sat_q[ch]) begin
        res[ch] = sem_pkg::ChanMax;
      end else if (rem_q[ch] > {9'b0, root_q[ch]}) begin
        res[ch] = root_q[ch] + 1'b1;
      end else begin
        res[ch] = root_q[ch];
      end
    end
  end

  // digit-by-digit root: remainder holds s - root^2
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.grad) begin
        gx_q[ch] <= gx_d[ch];
        gy_q[ch] <= gy_d[ch];
      end
      if (cmd_i.sqr) begin
        sat_q[ch]  <= sum_d[ch] > sem_pkg::SatLimit;
        rem_q[ch]  <= sum_d[ch][sem_pkg::RemW-1:0];
        root_q[ch] <= '0;
      end
      if (cmd_i.root && rem_q[ch] >= trial[ch]) begin
        rem_q[ch]  <= rem_q[ch] - trial[ch];
        root_q[ch] <= root_q[ch] | bitv;
      end
    end
  end

  // output register
  logic              out_valid_q;
  sem_pkg::sem_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.edge_red   <= res[0];
      out_q.edge_green <= res[1];
      out_q.edge_blue  <= res[2];
      out_q.frame_end  <= frame_end_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.drop      = (in_data_i.mode == sem_pkg::ModeFlush) && in_frame;
  assign sts_o.emit      = emit;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

// ===== test/sobel_edge_magnitude_rgb_core_test.sv =====
// Stimulus, Sobel magnitude predictor and result checks for the RGB Sobel edge core.
module sobel_edge_magnitude_rgb_core_test;

  localparam int MaxCols = 1024;
  localparam int IdleGap = 24;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  sem_pkg::sem_in_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  sem_pkg::sem_out_t out_data_o;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [sem_pkg::CfgDataW-1:0] cfg_data_i;

  sobel_edge_magnitude_rgb_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [sem_pkg::PixW-1:0] upper_row [MaxCols];
  logic [sem_pkg::PixW-1:0] middle_row [MaxCols];
  logic [sem_pkg::PixW-1:0] win [3][3];
  int unsigned col_pos, row_pos, edge_count, width_reg, height_reg;
  bit frame_closed;

  sem_pkg::sem_out_t edge_q[$];
  int errors = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;

  function automatic int unsigned round_root(int unsigned s);
    int unsigned r = 0;
    int unsigned t;
    if (s > 65280) return 255;
    for (int b = 128; b != 0; b >>= 1) begin
      t = r + b;
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic bit predict_edge(sem_pkg::sem_in_t d, output sem_pkg::sem_out_t res);
    int unsigned w, h, col, row, crow, ccol;
    logic [sem_pkg::PixW-1:0] pix, up, mid;
    bit emit;
    bit row_ok[3], col_ok[3];
    int gx, gy, v;
    int unsigned mag[3];
    res = '0;
    w = (width_reg == 0) ? 1 : ((width_reg > MaxCols) ? MaxCols : width_reg);
    h = (height_reg == 0) ? 1 : height_reg;
    if (col_pos >= w) col_pos = 0;
    col = col_pos;
    row = row_pos;
    if (d.mode == sem_pkg::ModeFlush && row < h) return 0;  // early flush dropped
    pix = (row < h) ? {d.pixel_red, d.pixel_green, d.pixel_blue} : '0;
    up = upper_row[col];
    mid = middle_row[col];
    upper_row[col] = mid;
    middle_row[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = up;
    win[1][2] = mid;
    win[2][2] = pix;
    emit = (row >= 2 || (row == 1 && col >= 1)) && edge_count < w * h;
    if (emit) begin
      crow = (col >= 1) ? row - 1 : row - 2;
      ccol = (col >= 1) ? col - 1 : w - 1;
      row_ok = '{crow > 0, 1'b1, crow + 1 < h};
      col_ok = '{ccol > 0, 1'b1, ccol + 1 < w};
      for (int ch = 0; ch < 3; ch++) begin
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++)
          for (int c = 0; c < 3; c++)
            if (row_ok[r] && col_ok[c]) begin
              v = int'(win[r][c][16-8*ch +: 8]);
              gx += v * (c - 1) * ((r == 1) ? 2 : 1);
              gy += v * (r - 1) * ((c == 1) ? 2 : 1);
            end
        mag[ch] = round_root(gx * gx + gy * gy);
      end
      res.edge_red = mag[0][7:0];
      res.edge_green = mag[1][7:0];
      res.edge_blue = mag[2][7:0];
      edge_count++;
      if (edge_count >= w * h) begin
        res.frame_end = 1'b1;
        col_pos = 0;
        row_pos = 0;
        edge_count = 0;
        frame_closed = 1;
        return 1;
      end
    end
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    col_pos = col;
    row_pos = row;
    return emit;
  endfunction

  task automatic send_word(sem_pkg::sem_in_t d);
    sem_pkg::sem_out_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= d;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (predict_edge(d, res)) edge_q.push_back(res);
  endtask

  function automatic sem_pkg::sem_in_t rand_pixel();
    sem_pkg::sem_in_t d;
    d.mode = sem_pkg::ModePixel;
    d.pixel_red = 8'($urandom);
    d.pixel_green = 8'($urandom);
    d.pixel_blue = 8'($urandom);
    return d;
  endfunction

  function automatic sem_pkg::sem_in_t flush_word();
    sem_pkg::sem_in_t d;
    d = rand_pixel();
    d.mode = sem_pkg::ModeFlush;
    return d;
  endfunction

  // registers change only with the core drained
  task automatic write_reg(logic idx, logic [sem_pkg::CfgDataW-1:0] val);
    in_valid_i <= 1'b0;
    wait (edge_q.size() == 0);
    repeat (IdleGap) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sem_pkg::CfgIdxWidth) width_reg = val[10:0];
    else height_reg = val;
    col_pos = 0;
    row_pos = 0;
    edge_count = 0;
  endtask

  task automatic drain_frame();
    while (!frame_closed) send_word(($urandom_range(4) == 0) ? rand_pixel() : flush_word());
  endtask

  task automatic run_frame(int n_pix, bit noisy);
    frame_closed = 0;
    for (int i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(15) == 0) send_word(flush_word());
      send_word(rand_pixel());
    end
    drain_frame();
  endtask

  task automatic test_tiny_frames();
    sem_pkg::sem_in_t d;
    write_reg(sem_pkg::CfgIdxWidth, 16'd0);
    write_reg(sem_pkg::CfgIdxHeight, 16'd0);
    frame_closed = 0;
    send_word(flush_word());
    d = rand_pixel();
    d.pixel_red = 8'hFF;
    d.pixel_green = 8'h00;
    d.pixel_blue = 8'h80;
    send_word(d);
    drain_frame();
    // 3x3 checkerboard of extremes drives the root into saturation
    write_reg(sem_pkg::CfgIdxWidth, 16'd3);
    write_reg(sem_pkg::CfgIdxHeight, 16'd3);
    frame_closed = 0;
    for (int i = 0; i < 9; i++) begin
      d.mode = sem_pkg::ModePixel;
      d.pixel_red = (i % 2) ? 8'hFF : 8'h00;
      d.pixel_green = (i % 2) ? 8'h00 : 8'hFF;
      d.pixel_blue = (i < 3) ? 8'hFF : 8'h01;
      send_word(d);
    end
    drain_frame();
    write_reg(sem_pkg::CfgIdxWidth, 16'd1);
    write_reg(sem_pkg::CfgIdxHeight, 16'd4);
    run_frame(4, 1'b0);
  endtask

  task automatic test_extreme_sizes();
    write_reg(sem_pkg::CfgIdxWidth, 16'd2);
    write_reg(sem_pkg::CfgIdxHeight, 16'hFFFF);
    for (int i = 0; i < 20; i++) send_word(rand_pixel());
    write_reg(sem_pkg::CfgIdxWidth, 16'd1025);  // clamps to the max row length
    write_reg(sem_pkg::CfgIdxHeight, 16'd2);
    for (int i = 0; i < 1100; i++) send_word(rand_pixel());
    write_reg(sem_pkg::CfgIdxWidth, 16'd2047);
    write_reg(sem_pkg::CfgIdxHeight, 16'd1);
    for (int i = 0; i < 30; i++) send_word(rand_pixel());
  endtask

  task automatic test_backpressure();
    write_reg(sem_pkg::CfgIdxWidth, 16'd8);
    write_reg(sem_pkg::CfgIdxHeight, 16'd6);
    hold_req = 400;
    frame_closed = 0;
    for (int i = 0; i < 48; i++) begin
      if (i == 30) begin
        in_valid_i <= 1'b0;
        wait (edge_q.size() == 0);
      end
      send_word(rand_pixel());
    end
    drain_frame();
  endtask

  task automatic test_random_frames(int stop_at);
    int w, h;
    while (words_sent < stop_at) begin
      if ($urandom_range(3) != 0) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        h = $urandom_range(6, 1);
        write_reg(sem_pkg::CfgIdxWidth, w[sem_pkg::CfgDataW-1:0]);
        write_reg(sem_pkg::CfgIdxHeight, h[sem_pkg::CfgDataW-1:0]);
      end
      w = (width_reg == 0) ? 1 : width_reg;
      h = (height_reg == 0) ? 1 : height_reg;
      run_frame(w * h, $urandom_range(1));
    end
  endtask

  // output side: random stalls plus an occasional long hold
  initial begin
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    sem_pkg::sem_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (edge_q.size() == 0) begin
        $error("unexpected word %h", out_data_o);
        errors++;
      end else begin
        want = edge_q.pop_front();
        if (out_data_o.edge_red !== want.edge_red) begin
          $error("edge_red exp %0d got %0d", want.edge_red, out_data_o.edge_red);
          errors++;
        end
        if (out_data_o.edge_green !== want.edge_green) begin
          $error("edge_green exp %0d got %0d", want.edge_green, out_data_o.edge_green);
          errors++;
        end
        if (out_data_o.edge_blue !== want.edge_blue) begin
          $error("edge_blue exp %0d got %0d", want.edge_blue, out_data_o.edge_blue);
          errors++;
        end
        if (out_data_o.frame_end !== want.frame_end) begin
          $error("frame_end exp %0b got %0b", want.frame_end, out_data_o.frame_end);
          errors++;
        end
      end
    end
  end

  initial begin
    #8000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= sem_pkg::CfgIdxWidth;
    cfg_data_i <= '0;
    width_reg = 640;
    height_reg = 480;
    col_pos = 0;
    row_pos = 0;
    edge_count = 0;
    for (int i = 0; i < MaxCols; i++) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    win = '{default: '0};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_tiny_frames();
    test_extreme_sizes();
    test_backpressure();
    test_random_frames(words_sent + 160);
    send_idle_pct = 87;
    test_random_frames(words_sent + 160);
    send_idle_pct = 0;
    stall_pct = 87;
    test_random_frames(words_sent + 160);
    send_idle_pct = 6;
    stall_pct = 6;
    test_random_frames(words_sent + 160);

    in_valid_i <= 1'b0;
    wait (edge_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sem_pkg.sv
rtl/core/sem_ram.sv
rtl/core/sem_ctrl.sv
rtl/core/sem_dp.sv
rtl/core/sobel_edge_magnitude_rgb_core.sv
test/sobel_edge_magnitude_rgb_core_test.sv
